// ===== hw/rtl/group_member_table_defines.svh =====
// assertion macros for the group member table
// depends on nothing; included by modules that assert
`ifndef GROUP_MEMBER_TABLE_DEFINES_SVH
`define GROUP_MEMBER_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define GMT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GMT_ASSERT_KNOWN(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) else $error(msg);
`else
`define GMT_ASSERT(label, clk, rst_n, prop, msg)
`define GMT_ASSERT_KNOWN(label, clk, rst_n, sig, msg)
`endif
`endif

// ===== hw/rtl/gmt_pkg.sv =====
// shared types and constants for the group member table
// depends on nothing
package gmt_pkg;
  localparam int unsigned Groups = 16;
  localparam int unsigned NodesPerGroup = 32;
  localparam int unsigned GroupW = (Groups > 1) ? $clog2(Groups) : 1;
  localparam int unsigned NodeW = (NodesPerGroup > 1) ? $clog2(NodesPerGroup) : 1;
  localparam int unsigned AddrW = GroupW + NodeW;
  localparam int unsigned Depth = Groups * NodesPerGroup;
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpDel = 2'd1,
    OpLookup = 2'd2,
    OpNone = 2'd3
  } op_e;

  typedef struct packed {
    op_e op;
    logic [31:0] group_id;
    logic [47:0] node_address;
  } cmd_t;

  typedef struct packed {
    logic status;
    logic found;
    logic [3:0] group_slot;
    logic group_freed;
    logic save_request;
  } res_t;
endpackage

// ===== hw/rtl/gmt_ram.sv =====
// generic single-port ram with registered read
// depends on nothing
module gmt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic clk_i,
  input  logic we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

// ===== hw/rtl/gmt_front.sv =====
// front end: accepts transactions and classifies the operation into a queue
// depends on gmt_pkg
`include "group_member_table_defines.svh"
module gmt_front (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [31:0] group_id_i,
  input  logic [47:0] node_address_i,
  output logic cmd_valid_o,
  input  logic cmd_pop_i,
  output gmt_pkg::cmd_t cmd_o
);
  import gmt_pkg::*;
  localparam int unsigned PtrW = $clog2(QDepth);

  cmd_t q_mem [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0] cnt_q;
  logic push;

  assign in_stall_o = (cnt_q == (PtrW+1)'(QDepth));
  assign push = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o = q_mem[rd_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= '{op: op_e'(operation_i), group_id: group_id_i,
                       node_address: node_address_i};
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (cmd_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(cmd_pop_i);
    end
  end

  `GMT_ASSERT(a_no_pop_empty, clk_i, rst_ni, cmd_pop_i |-> cmd_valid_o, "pop of empty queue")
  `GMT_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= (PtrW+1)'(QDepth), "queue count overflow")
  `GMT_ASSERT_KNOWN(a_valid_known, clk_i, rst_ni, cmd_valid_o, "queue valid unknown")
endmodule

// ===== hw/rtl/gmt_back.sv =====
// back end: scans group ids and node slots and updates the store
// depends on gmt_pkg, gmt_ram
`include "group_member_table_defines.svh"
module gmt_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_pop_o,
  input  gmt_pkg::cmd_t cmd_i,
  output logic res_valid_o,
  input  logic res_stall_i,
  output gmt_pkg::res_t res_o
);
  import gmt_pkg::*;

  typedef enum logic [3:0] {
    SClear, SIdle, SGrp, SNodeRd, SNodeChk, SWrite, SEmptyRd, SEmptyChk, SDone
  } state_e;

  state_e state_q;
  cmd_t cmd_q;
  logic [31:0] gid_q [Groups];
  logic [GroupW:0] gi_q;
  logic [NodeW:0] ni_q;
  logic [GroupW-1:0] slot_q, free_slot_q;
  logic have_match_q, have_free_q;
  logic [NodeW-1:0] nfree_q;
  logic have_nfree_q;
  logic [AddrW-1:0] clr_q;
  res_t res_q;
  logic res_valid_q;

  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [47:0] ram_wdata, ram_rdata;
  logic [NodeW-1:0] ni_idx;
  logic [GroupW-1:0] gi_idx;

  assign ni_idx = ni_q[NodeW-1:0];
  assign gi_idx = gi_q[GroupW-1:0];

  gmt_ram #(.Width(48), .Depth(Depth)) u_ram (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  // ram port control
  always_comb begin
    ram_we = 1'b0;
    ram_wdata = '0;
    ram_addr = AddrW'(slot_q) * AddrW'(NodesPerGroup) + AddrW'(ni_idx);
    unique case (state_q)
      SClear: begin
        ram_we = 1'b1;
        ram_addr = clr_q;
      end
      SWrite: begin
        ram_we = 1'b1;
        ram_wdata = (cmd_q.op == OpAdd) ? cmd_q.node_address : 48'd0;
      end
      default: ;
    endcase
  end

  assign cmd_pop_o = (state_q == SIdle) && cmd_valid_i && !res_valid_q;
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      clr_q <= '0;
      res_valid_q <= 1'b0;
      cmd_q <= '0;
      gi_q <= '0;
      ni_q <= '0;
      slot_q <= '0;
      free_slot_q <= '0;
      have_match_q <= 1'b0;
      have_free_q <= 1'b0;
      nfree_q <= '0;
      have_nfree_q <= 1'b0;
      res_q <= '0;
      for (int i = 0; i < Groups; i++) gid_q[i] <= '0;
    end else begin
      if (res_valid_q && !res_stall_i) res_valid_q <= 1'b0;
      unique case (state_q)
        SClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AddrW'(Depth - 1)) state_q <= SIdle;
        end
        SIdle: begin
          if (cmd_pop_o) begin
            cmd_q <= cmd_i;
            gi_q <= '0;
            have_match_q <= 1'b0;
            have_free_q <= 1'b0;
            res_q <= '0;
            state_q <= (cmd_i.op == OpNone) ? SDone : SGrp;
          end
        end
        SGrp: begin
          if (gi_q == (GroupW+1)'(Groups)) begin
            ni_q <= '0;
            have_nfree_q <= 1'b0;
            unique case (cmd_q.op)
              OpLookup: begin
                res_q.found <= have_match_q;
                res_q.group_slot <= have_match_q ? 4'(slot_q) : 4'd0;
                state_q <= SDone;
              end
              OpDel: begin
                res_q.save_request <= 1'b1;
                state_q <= have_match_q ? SNodeRd : SDone;
              end
              default: begin
                if (have_match_q) state_q <= SNodeRd;
                else if (have_free_q) begin
                  slot_q <= free_slot_q;
                  gid_q[free_slot_q] <= cmd_q.group_id;
                  state_q <= SNodeRd;
                end else begin
                  res_q.status <= 1'b1;
                  state_q <= SDone;
                end
              end
            endcase
          end else begin
            if (!have_match_q && gid_q[gi_idx] == cmd_q.group_id) begin
              have_match_q <= 1'b1;
              slot_q <= gi_idx;
            end
            if (!have_free_q && gid_q[gi_idx] == 32'd0) begin
              have_free_q <= 1'b1;
              free_slot_q <= gi_idx;
            end
            gi_q <= gi_q + 1'b1;
          end
        end
        SNodeRd: begin
          if (ni_q == (NodeW+1)'(NodesPerGroup)) begin
            // add scan finished without a match
            if (have_nfree_q) begin
              ni_q <= (NodeW+1)'(nfree_q);
              res_q.save_request <= 1'b1;
              state_q <= SWrite;
            end else begin
              res_q.status <= 1'b1;
              state_q <= SDone;
            end
          end else state_q <= SNodeChk;
        end
        SNodeChk: begin
          if (ram_rdata == cmd_q.node_address) begin
            if (cmd_q.op == OpAdd) begin
              res_q.save_request <= 1'b1;
              state_q <= SDone;
            end else state_q <= SWrite;
          end else begin
            if (!have_nfree_q && ram_rdata == 48'd0) begin
              have_nfree_q <= 1'b1;
              nfree_q <= ni_idx;
            end
            ni_q <= ni_q + 1'b1;
            state_q <= (cmd_q.op == OpDel && ni_q == (NodeW+1)'(NodesPerGroup - 1))
                       ? SDone : SNodeRd;
          end
        end
        SWrite: begin
          ni_q <= '0;
          state_q <= (cmd_q.op == OpDel) ? SEmptyRd : SDone;
        end
        SEmptyRd: begin
          if (ni_q == (NodeW+1)'(NodesPerGroup)) begin
            gid_q[slot_q] <= 32'd0;
            res_q.group_freed <= 1'b1;
            state_q <= SDone;
          end else state_q <= SEmptyChk;
        end
        SEmptyChk: begin
          if (ram_rdata != 48'd0) state_q <= SDone;
          else begin
            ni_q <= ni_q + 1'b1;
            state_q <= SEmptyRd;
          end
        end
        SDone: begin
          res_valid_q <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  `GMT_ASSERT(a_pop_idle, clk_i, rst_ni, cmd_pop_o |=> (state_q != SIdle), "pop left idle")
  `GMT_ASSERT(a_res_hold, clk_i, rst_ni, (res_valid_q && res_stall_i) |=> res_valid_q, "result dropped")
  `GMT_ASSERT(a_done_once, clk_i, rst_ni, (state_q == SDone) |-> !res_valid_q || !res_stall_i, "result overrun")
  `GMT_ASSERT_KNOWN(a_res_valid_known, clk_i, rst_ni, res_valid_q, "result valid unknown")
endmodule

// ===== hw/rtl/group_member_table.sv =====
// Group member table: 16 group slots of 32 node addresses each. One transaction
// at a time runs in the back end: a scan of the group ids (one slot a cycle),
// then, for add and delete, a read and a check per node slot over the single node
// ram port. After reset a clearing pass writes zero to all 512 node entries, one
// a cycle; during it up to two transactions are queued but none is carried out.
// A two-entry command queue in front and a result register decouple the two sides.
// depends on gmt_pkg, gmt_front, gmt_back
module group_member_table (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [31:0] group_id_i,
  input  logic [47:0] node_address_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic status_o,
  output logic found_o,
  output logic [3:0] group_slot_o,
  output logic group_freed_o,
  output logic save_request_o
);
  import gmt_pkg::*;

  cmd_t cmd;
  res_t res;
  logic cmd_valid, cmd_pop;

  gmt_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i, .group_id_i,
    .node_address_i, .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  gmt_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .res_valid_o(out_valid_o), .res_stall_i(out_stall_i), .res_o(res)
  );

  assign status_o = res.status;
  assign found_o = res.found;
  assign group_slot_o = res.group_slot;
  assign group_freed_o = res.group_freed;
  assign save_request_o = res.save_request;
endmodule

// ===== sim/gmt_checker.sv =====
// membership checker: watches both channels of the group member table,
// predicts each result from its own copy of the table and compares
// depends on gmt_pkg
`timescale 1ns / 100ps
module gmt_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  operation_i,
  input  logic [31:0] group_id_i,
  input  logic [47:0] node_address_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        status_i,
  input  logic        found_i,
  input  logic [3:0]  group_slot_i,
  input  logic        group_freed_i,
  input  logic        save_request_i,
  output int          fail_count_o,
  output int          pending_o
);
  import gmt_pkg::*;

  logic [31:0] grp_tab [Groups];
  logic [47:0] node_tab [Groups][NodesPerGroup];
  res_t expected_q [$];

  assign pending_o = expected_q.size();

  initial begin
    fail_count_o = 0;
    foreach (grp_tab[g]) grp_tab[g] = '0;
    foreach (node_tab[g, n]) node_tab[g][n] = '0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // lowest slot holding the id, -1 if none
  function automatic int find_slot(input logic [31:0] gid);
    for (int g = 0; g < Groups; g++) if (grp_tab[g] == gid) return g;
    return -1;
  endfunction

  function automatic res_t table_update(input op_e op, input logic [31:0] gid,
                                        input logic [47:0] addr);
    res_t r;
    int   g;
    int   free_n;
    bit   ok;
    bit   hit;
    bit   empty;
    r = '0;
    g = find_slot(gid);
    case (op)
      OpAdd: begin
        if (g < 0) begin
          g = find_slot('0);
          if (g >= 0) grp_tab[g] = gid;
        end
        ok = 0;
        if (g >= 0) begin
          free_n = -1;
          for (int n = 0; n < NodesPerGroup; n++) begin
            if (node_tab[g][n] == addr) begin
              ok = 1;
              break;
            end
            if (node_tab[g][n] == '0 && free_n < 0) free_n = n;
          end
          if (!ok && free_n >= 0) begin
            node_tab[g][free_n] = addr;
            ok = 1;
          end
        end
        r.status = !ok;
        r.save_request = ok;
      end
      OpDel: begin
        if (g >= 0) begin
          hit = 0;
          for (int n = 0; n < NodesPerGroup; n++) begin
            if (node_tab[g][n] == addr) begin
              node_tab[g][n] = '0;
              hit = 1;
              break;
            end
          end
          if (hit) begin
            empty = 1;
            for (int n = 0; n < NodesPerGroup; n++) if (node_tab[g][n] != '0) empty = 0;
            if (empty) begin
              grp_tab[g] = '0;
              r.group_freed = 1;
            end
          end
        end
        r.save_request = 1;
      end
      OpLookup: begin
        if (g >= 0) begin
          r.found = 1;
          r.group_slot = g[3:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // predict on accepted commands, compare on accepted results
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(table_update(op_e'(operation_i), group_id_i, node_address_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          want = expected_q.pop_front();
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
          if (found_i !== want.found) report_mismatch("found", found_i, want.found);
          if (group_slot_i !== want.group_slot)
            report_mismatch("group_slot", group_slot_i, want.group_slot);
          if (group_freed_i !== want.group_freed)
            report_mismatch("group_freed", group_freed_i, want.group_freed);
          if (save_request_i !== want.save_request)
            report_mismatch("save_request", save_request_i, want.save_request);
        end
      end
    end
  end
endmodule

// ===== sim/tb_group_member_table.sv =====
// stimulus and verdict for the group member table
// depends on gmt_pkg, group_member_table, gmt_checker
`timescale 1ns / 100ps
module tb_group_member_table;
  import gmt_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  operation_i = 0;
  logic [31:0] group_id_i = 0;
  logic [47:0] node_address_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic        status_o, found_o, group_freed_o, save_request_o;
  logic [3:0]  group_slot_o;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic [31:0] gid_pool [8];
  logic [47:0] addr_pool [48];

  always #4 clk_i = ~clk_i;

  group_member_table i_dut (.*);

  gmt_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .operation_i, .group_id_i,
    .node_address_i, .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .found_i(found_o), .group_slot_i(group_slot_o), .group_freed_i(group_freed_o),
    .save_request_i(save_request_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // random receiver stall
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  // one command transaction, with random sender gaps before it; valid stays
  // high afterwards until the next gap or an explicit idle
  task automatic send_cmd(input op_e op, input logic [31:0] gid, input logic [47:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    operation_i <= op;
    group_id_i <= gid;
    node_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_random;
    int   k;
    op_e  op;
    logic [31:0] gid;
    logic [47:0] addr;
    k = $urandom_range(99);
    op = (k < 50) ? OpAdd : (k < 80) ? OpDel : (k < 96) ? OpLookup : OpNone;
    gid = ($urandom_range(9) == 0) ? $urandom : gid_pool[$urandom_range(7)];
    addr = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom})
                                    : addr_pool[$urandom_range(47)];
    send_cmd(op, gid, addr);
  endtask

  initial begin
    foreach (gid_pool[i]) gid_pool[i] = (i == 0) ? 32'hffff_ffff : $urandom;
    foreach (addr_pool[i]) addr_pool[i] = (i == 0) ? '1 : 48'({$urandom, $urandom});
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    // directed: extremes, all codes, zero ids and addresses
    send_cmd(OpLookup, 32'hffff_ffff, '0);
    send_cmd(OpAdd, 32'hffff_ffff, '1);
    send_cmd(OpLookup, 32'hffff_ffff, '0);
    send_cmd(OpAdd, 32'hffff_ffff, '1);
    send_cmd(OpAdd, '0, 48'h1);
    send_cmd(OpLookup, '0, '0);
    send_cmd(OpDel, '0, 48'h1);
    send_cmd(OpAdd, 32'h5, '0);
    send_cmd(OpDel, 32'h5, '0);
    send_cmd(OpNone, 32'h5, '1);
    send_cmd(OpDel, 32'h77, 48'h3);
    send_cmd(OpDel, 32'hffff_ffff, 48'h2);
    send_cmd(OpDel, 32'hffff_ffff, '1);
    send_cmd(OpLookup, 32'hffff_ffff, '0);
    // fill one group past its node slots, then fill all group slots
    for (int n = 0; n < NodesPerGroup + 1; n++) send_cmd(OpAdd, 32'h1234, 48'h100 + n);
    for (int g = 0; g < Groups + 1; g++) send_cmd(OpAdd, 32'h9000 + g, 48'h55);
    send_cmd(OpLookup, 32'h9000 + Groups - 2, '0);
    for (int g = 0; g < Groups + 1; g++) send_cmd(OpDel, 32'h9000 + g, 48'h55);
    for (int n = 0; n < NodesPerGroup; n++) send_cmd(OpDel, 32'h1234, 48'h100 + n);
    // pause until drained
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    send_idle_pct = 11;
    recv_idle_pct = 62;
    for (int i = 0; i < 230; i++) send_random();
    send_idle_pct = 62;
    recv_idle_pct = 11;
    for (int i = 0; i < 230; i++) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 230; i++) send_random();
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
